FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the translator RTL.
// Every check is clocked on the rising edge and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define TFCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication check.
`define TFCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tfct_pkg.sv
// ----------------------------------------------------------------------------
// tfct_pkg
// Types, microcode layout and the microcode table of the time format
// code translator.
// ----------------------------------------------------------------------------
package tfct_pkg;

    localparam int BUDGET_WIDTH_DEF = 16;
    localparam logic [15:0] BUF_LEN_RESET = 16'd64;

    localparam int UCODE_DEPTH = 34;
    localparam int PC_W = $clog2(UCODE_DEPTH);

    // Entry points into the microcode table.
    localparam logic [PC_W-1:0] UA_LIT  = PC_W'(0);
    localparam logic [PC_W-1:0] UA_STAT = PC_W'(1);
    localparam logic [PC_W-1:0] UA_R12  = PC_W'(2);
    localparam logic [PC_W-1:0] UA_T24  = PC_W'(13);
    localparam logic [PC_W-1:0] UA_R24  = PC_W'(21);
    localparam logic [PC_W-1:0] UA_H24  = PC_W'(26);
    localparam logic [PC_W-1:0] UA_H12  = PC_W'(28);
    localparam logic [PC_W-1:0] UA_AMPM = PC_W'(30);
    localparam logic [PC_W-1:0] UA_SEC  = PC_W'(32);

    typedef enum logic [1:0] {
        SRC_ROM  = 2'd0,
        SRC_LIT  = 2'd1,
        SRC_STAT = 2'd2
    } t_src;

    // One control word: where the character comes from, the character
    // itself for table strings, and the end-of-run flag that returns the
    // sequencer to idle.
    typedef struct packed {
        t_src        src;
        logic [7:0]  ch;
        logic        last;
    } t_uword;

    // Request handed from the decoder to the sequencer.
    typedef struct packed {
        logic            go;
        logic [PC_W-1:0] start;
        logic [7:0]      lit;
        logic            ok;
    } t_launch;

    function automatic t_uword uw(input t_src s, input logic [7:0] c, input logic l);
        t_uword w;
        w.src  = s;
        w.ch   = c;
        w.last = l;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            6'd0:    w = uw(SRC_LIT,  8'h00, 1'b1);
            6'd1:    w = uw(SRC_STAT, 8'h00, 1'b1);
            // "hh:mm:ss tt"
            6'd2:    w = uw(SRC_ROM, "h", 1'b0);
            6'd3:    w = uw(SRC_ROM, "h", 1'b0);
            6'd4:    w = uw(SRC_ROM, ":", 1'b0);
            6'd5:    w = uw(SRC_ROM, "m", 1'b0);
            6'd6:    w = uw(SRC_ROM, "m", 1'b0);
            6'd7:    w = uw(SRC_ROM, ":", 1'b0);
            6'd8:    w = uw(SRC_ROM, "s", 1'b0);
            6'd9:    w = uw(SRC_ROM, "s", 1'b0);
            6'd10:   w = uw(SRC_ROM, " ", 1'b0);
            6'd11:   w = uw(SRC_ROM, "t", 1'b0);
            6'd12:   w = uw(SRC_ROM, "t", 1'b1);
            // "HH:mm:ss"
            6'd13:   w = uw(SRC_ROM, "H", 1'b0);
            6'd14:   w = uw(SRC_ROM, "H", 1'b0);
            6'd15:   w = uw(SRC_ROM, ":", 1'b0);
            6'd16:   w = uw(SRC_ROM, "m", 1'b0);
            6'd17:   w = uw(SRC_ROM, "m", 1'b0);
            6'd18:   w = uw(SRC_ROM, ":", 1'b0);
            6'd19:   w = uw(SRC_ROM, "s", 1'b0);
            6'd20:   w = uw(SRC_ROM, "s", 1'b1);
            // "HH:mm"
            6'd21:   w = uw(SRC_ROM, "H", 1'b0);
            6'd22:   w = uw(SRC_ROM, "H", 1'b0);
            6'd23:   w = uw(SRC_ROM, ":", 1'b0);
            6'd24:   w = uw(SRC_ROM, "m", 1'b0);
            6'd25:   w = uw(SRC_ROM, "m", 1'b1);
            // "HH", "hh", "tt", "ss"
            6'd26:   w = uw(SRC_ROM, "H", 1'b0);
            6'd27:   w = uw(SRC_ROM, "H", 1'b1);
            6'd28:   w = uw(SRC_ROM, "h", 1'b0);
            6'd29:   w = uw(SRC_ROM, "h", 1'b1);
            6'd30:   w = uw(SRC_ROM, "t", 1'b0);
            6'd31:   w = uw(SRC_ROM, "t", 1'b1);
            6'd32:   w = uw(SRC_ROM, "s", 1'b0);
            6'd33:   w = uw(SRC_ROM, "s", 1'b1);
            default: w = uw(SRC_STAT, 8'h00, 1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/tfct_useq.sv
// ----------------------------------------------------------------------------
// tfct_useq
// Microcode sequencer and output register: steps through the control words
// of one run and presents one result per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfct_useq
    import tfct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_launch    i_launch,
    output logic       o_busy,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_is_status,
    output logic       o_succeeded,
    output logic       o_last_of_run
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_lit;
    logic            r_ok;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_is_status;
    logic            r_succeeded;
    logic            r_last;

    t_uword          w_word;
    logic            w_adv;
    logic [7:0]      n_char;
    logic            n_status;
    logic            n_ok;

    assign w_word = ucode(r_pc);
    assign w_adv  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_char   = 8'h00;
        n_status = 1'b0;
        n_ok     = 1'b0;
        unique case (w_word.src)
            SRC_ROM: begin
                n_char = w_word.ch;
            end
            SRC_LIT: begin
                n_char = r_lit;
            end
            SRC_STAT: begin
                n_status = 1'b1;
                n_ok     = r_ok;
            end
            default: begin
                n_char = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (i_launch.go) begin
                r_busy <= 1'b1;
                r_pc   <= i_launch.start;
                r_lit  <= i_launch.lit;
                r_ok   <= i_launch.ok;
            end else if (r_busy && w_adv) begin
                r_pc <= r_pc + 1'b1;
                if (w_word.last) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (r_busy && w_adv) begin
            r_out_char  <= n_char;
            r_is_status <= n_status;
            r_succeeded <= n_ok;
            r_last      <= w_word.last;
        end
    end

    assign o_busy        = r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_is_status   = r_is_status;
    assign o_succeeded   = r_succeeded;
    assign o_last_of_run = r_last;

    `TFCT_ASSERT_IMP(a_status_ends_run, i_clk, i_rst_n, r_out_valid && r_is_status, r_last, "status result must close its run")
    `TFCT_ASSERT_IMP(a_pc_in_table, i_clk, i_rst_n, r_busy, r_pc < PC_W'(UCODE_DEPTH), "step counter ran past the microcode table")

endmodule

FILE: rtl/time_format_code_translator.sv
// Result path: an accepted request loads the microcode step counter; each result is then
// registered in the output register. The sequencer takes no new request until it has
// stepped through every result of the current one; a request with no result leaves it
// idle. Throughput: the single step counter moves one word per cycle unless output stalls.
// Reset (synchronous, active low): buffer length 64, normal mode, budget 63, sequencer idle,
// output register empty.
// ----------------------------------------------------------------------------
// time_format_code_translator
// Translates strftime-style time pattern bytes into a picture-style pattern,
// one output character per result, with an all-or-nothing output budget.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module time_format_code_translator
    import tfct_pkg::*;
#(
    parameter int BUDGET_WIDTH = BUDGET_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Pattern byte channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    // Translated character channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_is_status,
    output logic        o_succeeded,
    output logic        o_last_of_run
);

    // Pattern bytes with a special meaning.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_PCT = "%";
    localparam logic [7:0] CH_BSL = 8'h5C;

    localparam int EXT_W = (BUDGET_WIDTH > 16) ? BUDGET_WIDTH : 16;
    localparam logic [BUDGET_WIDTH-1:0] BUDGET_MAX = '1;

    typedef enum logic [2:0] {
        M_NORMAL  = 3'd0,
        M_ESCAPE  = 3'd1,
        M_CODE    = 3'd2,
        M_STOPPED = 3'd3,
        M_FAILED  = 3'd4
    } t_mode;

    // The budget is one less than the buffer length, zero for an empty
    // buffer, and saturates when the budget register is narrower.
    function automatic logic [BUDGET_WIDTH-1:0] f_reload(input logic [15:0] bl);
        logic [EXT_W-1:0] m;
        m = (bl == 16'd0) ? '0 : EXT_W'(bl - 16'd1);
        if (m > EXT_W'(BUDGET_MAX)) begin
            m = EXT_W'(BUDGET_MAX);
        end
        return BUDGET_WIDTH'(m);
    endfunction

    logic [15:0]             r_buf_len;
    t_mode                   r_mode;
    t_mode                   n_mode;
    logic [BUDGET_WIDTH-1:0] r_budget;
    logic [BUDGET_WIDTH-1:0] n_budget;

    t_launch                 w_launch;
    logic                    w_busy;
    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_reload;
    logic                    w_want;
    logic [3:0]              w_len;
    logic [PC_W-1:0]         w_start;
    logic [7:0]              w_lit;

    // A new request is taken whenever the sequencer is idle, even while the
    // last result of the previous one still sits in the output register.
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    // Register zero lives at byte address 0; the upper word is outside the map.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {16'd0, r_buf_len};

    // A zero byte ends the pattern and restarts the budget for the next one.
    assign w_reload = w_cfg_wr || (w_accept && (i_char_code == CH_NUL));

    // Decoder: classifies the accepted byte, charges the budget for the whole
    // expansion at once, and hands a start address to the sequencer.
    always_comb begin
        n_mode   = r_mode;
        n_budget = r_budget;
        w_want   = 1'b0;
        w_len    = 4'd1;
        w_start  = UA_LIT;
        w_lit    = i_char_code;
        w_launch = '0;
        if (w_accept) begin
            if (i_char_code == CH_NUL) begin
                w_launch.go    = 1'b1;
                w_launch.start = UA_STAT;
                w_launch.ok    = (r_mode != M_FAILED);
                n_mode         = M_NORMAL;
                n_budget       = f_reload(r_buf_len);
            end else begin
                unique case (r_mode)
                    M_NORMAL: begin
                        if (i_char_code == CH_PCT) begin
                            n_mode = M_CODE;
                        end else if (i_char_code == CH_BSL) begin
                            n_mode = M_ESCAPE;
                        end else begin
                            w_want = 1'b1;
                        end
                    end
                    M_ESCAPE: begin
                        n_mode = M_NORMAL;
                        w_want = 1'b1;
                    end
                    M_CODE: begin
                        n_mode = M_NORMAL;
                        w_want = 1'b1;
                        case (i_char_code) inside
                            "n": w_lit = CH_LF;
                            "t": w_lit = CH_TAB;
                            "%": w_lit = CH_PCT;
                            "H": begin
                                w_start = UA_H24;
                                w_len   = 4'd2;
                            end
                            "I": begin
                                w_start = UA_H12;
                                w_len   = 4'd2;
                            end
                            "p": begin
                                w_start = UA_AMPM;
                                w_len   = 4'd2;
                            end
                            "r": begin
                                w_start = UA_R12;
                                w_len   = 4'd11;
                            end
                            "R": begin
                                w_start = UA_R24;
                                w_len   = 4'd5;
                            end
                            "S": begin
                                w_start = UA_SEC;
                                w_len   = 4'd2;
                            end
                            "T", "X": begin
                                w_start = UA_T24;
                                w_len   = 4'd8;
                            end
                            default: begin
                                // An unknown code ends translation quietly.
                                w_want = 1'b0;
                                n_mode = M_STOPPED;
                            end
                        endcase
                    end
                    M_STOPPED, M_FAILED: begin
                        n_mode = r_mode;
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
                if (w_want) begin
                    if (r_budget < BUDGET_WIDTH'(w_len)) begin
                        n_mode = M_FAILED;
                    end else begin
                        n_budget       = r_budget - BUDGET_WIDTH'(w_len);
                        w_launch.go    = 1'b1;
                        w_launch.start = w_start;
                        w_launch.lit   = w_lit;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len <= BUF_LEN_RESET;
            r_mode    <= M_NORMAL;
            r_budget  <= f_reload(BUF_LEN_RESET);
        end else if (w_cfg_wr) begin
            r_buf_len <= pwdata[15:0];
            r_mode    <= M_NORMAL;
            r_budget  <= f_reload(pwdata[15:0]);
        end else begin
            r_mode   <= n_mode;
            r_budget <= n_budget;
        end
    end

    tfct_useq u_useq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_launch      (w_launch),
        .o_busy        (w_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_is_status   (o_is_status),
        .o_succeeded   (o_succeeded),
        .o_last_of_run (o_last_of_run)
    );

    `TFCT_ASSERT(a_budget_only_falls, i_clk, i_rst_n, !w_reload |=> (r_budget <= $past(r_budget)), "budget grew without a restart")
    `TFCT_ASSERT(a_failed_sticks, i_clk, i_rst_n, (r_mode == M_FAILED) && !w_reload |=> (r_mode == M_FAILED), "failed mode left before end of pattern")

endmodule

FILE: tb/tb_time_format_code_translator.sv
// ----------------------------------------------------------------------------
// tb_time_format_code_translator
// Self-checking testbench for the time format code translator. A directed
// table of pattern bytes opens the run, then random well-formed patterns and
// random noise bytes follow under several buffer lengths. Every output
// character is checked against the bench's own model or a typed-in result.
// ----------------------------------------------------------------------------
module tb_time_format_code_translator;
    timeunit 1ns;
    timeprecision 1ps;

    import tfct_pkg::*;

    // Bytes with a special meaning in the pattern language.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Letters that may follow a percent sign.
    localparam logic [7:0] CODE_NEWLINE     = "n";
    localparam logic [7:0] CODE_TAB         = "t";
    localparam logic [7:0] CODE_HOUR24      = "H";
    localparam logic [7:0] CODE_HOUR12      = "I";
    localparam logic [7:0] CODE_AMPM        = "p";
    localparam logic [7:0] CODE_CLOCK12     = "r";
    localparam logic [7:0] CODE_CLOCK24_HM  = "R";
    localparam logic [7:0] CODE_SECONDS     = "S";
    localparam logic [7:0] CODE_CLOCK24     = "T";
    localparam logic [7:0] CODE_LOCALE_TIME = "X";
    localparam logic [7:0] CODE_BOGUS       = "Q";

    localparam logic [7:0] TIME_CODES [11] = '{
        CODE_NEWLINE, CODE_TAB, CH_PERCENT, CODE_HOUR24, CODE_HOUR12, CODE_AMPM,
        CODE_CLOCK12, CODE_CLOCK24_HM, CODE_SECONDS, CODE_CLOCK24, CODE_LOCALE_TIME
    };

    // Register byte addresses: the buffer length, and one unused slot.
    localparam logic [2:0] ADDR_BUF_LEN = 3'd0;
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 50;

    // Buffer lengths of the random phases; one more random length follows.
    localparam logic [15:0] PHASE_LENGTHS [6] = '{
        16'hFFFF, 16'd1, 16'd24, 16'd0, 16'd64, 16'd9
    };
    localparam int CALM_PHASE = 4;

    typedef enum logic [2:0] {
        SCAN_PLAIN,
        SCAN_ESCAPE,
        SCAN_CODE,
        SCAN_HALTED,
        SCAN_OVERFLOW
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       status;
        logic       fit;
        logic       last;
    } t_out_char;

    // ROW_SEND rows are checked against the model, ROW_CHECK rows carry a
    // single typed-in result, ROW_LENGTH rows rewrite the buffer length.
    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_CHECK,
        ROW_LENGTH
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] data;
        logic [7:0]  e_char;
        logic        e_status;
        logic        e_fit;
    } t_row;

    localparam int NUM_ROWS = 40;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // Extremes of the byte range pass straight through.
        '{ROW_CHECK,  {8'h00, 8'h01},             8'h01, 1'b0, 1'b0},
        '{ROW_CHECK,  {8'h00, 8'hFF},             8'hFF, 1'b0, 1'b0},
        // An escaped percent sign is a literal.
        '{ROW_SEND,   {8'h00, CH_BACKSLASH},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        // Every supported code once.
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_NEWLINE},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_TAB},          8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_HOUR24},       8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_HOUR12},       8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_AMPM},         8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_CLOCK12},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_CLOCK24_HM},   8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_SECONDS},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_CLOCK24},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_LOCALE_TIME},  8'h00, 1'b0, 1'b0},
        // A dangling percent sign still ends the pattern as a success.
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_CHECK,  {8'h00, CH_NUL},            8'h00, 1'b1, 1'b1},
        // A budget of two cannot hold the twelve-hour clock: overflow, and
        // the byte after it is ignored.
        '{ROW_LENGTH, 16'd3,                      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_CLOCK12},      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, 8'h7A},             8'h00, 1'b0, 1'b0},
        '{ROW_CHECK,  {8'h00, CH_NUL},            8'h00, 1'b1, 1'b0},
        // An unsupported code stops quietly and still succeeds.
        '{ROW_SEND,   {8'h00, CH_PERCENT},        8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, CODE_BOGUS},        8'h00, 1'b0, 1'b0},
        '{ROW_CHECK,  {8'h00, CH_NUL},            8'h00, 1'b1, 1'b1},
        // A dangling backslash also succeeds.
        '{ROW_SEND,   {8'h00, CH_BACKSLASH},      8'h00, 1'b0, 1'b0},
        '{ROW_CHECK,  {8'h00, CH_NUL},            8'h00, 1'b1, 1'b1},
        // A zero buffer length leaves no room even for one plain byte.
        '{ROW_LENGTH, 16'd0,                      8'h00, 1'b0, 1'b0},
        '{ROW_SEND,   {8'h00, 8'h61},             8'h00, 1'b0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_code   = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_is_status;
    logic        o_succeeded;
    logic        o_last_of_run;

    // Model state: the register, the parse mode and the remaining budget.
    logic [15:0] buf_len;
    logic [15:0] budget;
    t_scan_mode  scan;
    bit          hold_results;

    // Output characters still owed by the block, oldest first.
    t_out_char   pending_chars [$];

    bit          traffic_gaps = 1'b1;
    int          live_items;
    int          mismatches;
    int          cycle_count;

    time_format_code_translator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_is_status   (o_is_status),
        .o_succeeded   (o_succeeded),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- model

    // A new pattern starts in plain mode with the full budget; one byte of
    // the buffer is kept back for the terminator.
    task automatic restart_pattern();
        budget = (buf_len == 16'd0) ? 16'd0 : buf_len - 16'd1;
        scan = SCAN_PLAIN;
    endtask

    task automatic queue_result(input logic [7:0] c, input logic st, input logic fit,
                                input logic last);
        if (!hold_results)
            pending_chars.push_back(t_out_char'{c, st, fit, last});
    endtask

    // Expansions are charged all or nothing: if the whole string does not
    // fit, nothing comes out and the pattern is marked as overflowed.
    task automatic emit_text(input string s);
        int k;
        if (budget < s.len()) begin
            scan = SCAN_OVERFLOW;
        end else begin
            budget -= 16'(s.len());
            for (k = 0; k < s.len(); k++)
                queue_result(s[k], 1'b0, 1'b0, k == s.len() - 1);
        end
    endtask

    task automatic emit_byte(input logic [7:0] c);
        if (budget == 16'd0) begin
            scan = SCAN_OVERFLOW;
        end else begin
            budget--;
            queue_result(c, 1'b0, 1'b0, 1'b1);
        end
    endtask

    // Advances the model by one accepted pattern byte and queues whatever
    // characters it produces.
    task automatic translate_byte(input logic [7:0] c);
        if (c == CH_NUL) begin
            queue_result(8'h00, 1'b1, scan != SCAN_OVERFLOW, 1'b1);
            restart_pattern();
        end else begin
            case (scan)
                SCAN_ESCAPE: begin
                    scan = SCAN_PLAIN;
                    emit_byte(c);
                end
                SCAN_CODE: begin
                    scan = SCAN_PLAIN;
                    case (c)
                        CODE_NEWLINE:     emit_byte(CH_LF);
                        CODE_TAB:         emit_byte(CH_TAB);
                        CH_PERCENT:       emit_byte(CH_PERCENT);
                        CODE_HOUR24:      emit_text("HH");
                        CODE_HOUR12:      emit_text("hh");
                        CODE_AMPM:        emit_text("tt");
                        CODE_CLOCK12:     emit_text("hh:mm:ss tt");
                        CODE_CLOCK24_HM:  emit_text("HH:mm");
                        CODE_SECONDS:     emit_text("ss");
                        CODE_CLOCK24,
                        CODE_LOCALE_TIME: emit_text("HH:mm:ss");
                        default:          scan = SCAN_HALTED;
                    endcase
                end
                SCAN_PLAIN: begin
                    if (c == CH_PERCENT)
                        scan = SCAN_CODE;
                    else if (c == CH_BACKSLASH)
                        scan = SCAN_ESCAPE;
                    else
                        emit_byte(c);
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------ request channel

    // Offers one pattern byte, sometimes after a short idle gap, and holds
    // it until the block takes it. The model runs at the accepting edge.
    task automatic send_byte(input logic [7:0] c);
        if (traffic_gaps && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_in_stall);
        translate_byte(c);
        live_items++;
    endtask

    // Stops offering requests until every owed character has come out.
    // At least one edge passes, so valid is never lowered and raised in
    // the same step.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // ------------------------------------------------------- register port

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Only the buffer length exists; a write to it restarts the pattern.
        if (addr == ADDR_BUF_LEN) begin
            buf_len = data[15:0];
            restart_pattern();
        end
    endtask

    task automatic cfg_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes the buffer length while the block is idle. The unused slot is
    // then written with junk, and the readback shows it left the real
    // register alone.
    task automatic apply_length(input logic [15:0] len);
        logic [31:0] rd;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(ADDR_BUF_LEN, {16'($urandom_range(16'hFFFF, 0)), len});
        cfg_write(ADDR_UNUSED, $urandom());
        cfg_read(ADDR_BUF_LEN, rd);
        if (rd[15:0] !== buf_len)
            report_mismatch($sformatf("buffer length reads %04h, wrote %04h",
                                      rd[15:0], buf_len));
    endtask

    // ------------------------------------------------------ random stimulus

    // One well-formed pattern: a few plain bytes, escapes and codes, closed
    // by a zero byte. A small share of codes is unsupported.
    task automatic send_pattern();
        int          n;
        int          r;
        logic [7:0]  c;
        n = $urandom_range(1, 8);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 40) begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_PERCENT || c == CH_BACKSLASH);
                send_byte(c);
            end else if (r < 55) begin
                send_byte(CH_BACKSLASH);
                send_byte(8'($urandom_range(1, 255)));
            end else if (r < 93) begin
                send_byte(CH_PERCENT);
                send_byte(TIME_CODES[$urandom_range(10)]);
            end else begin
                send_byte(CH_PERCENT);
                send_byte(8'($urandom_range(1, 255)));
            end
        end
        send_byte(CH_NUL);
    endtask

    // Raw bytes from the whole range, zero included.
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // -------------------------------------------------------------- checker

    // Each character the block hands over is matched against the oldest
    // one the model owes.
    always @(posedge i_clk) begin
        t_out_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected result char=%02h status=%0b ok=%0b last=%0b",
                                          o_out_char, o_is_status, o_succeeded,
                                          o_last_of_run));
            end else begin
                want = pending_chars.pop_front();
                if (o_out_char !== want.ch || o_is_status !== want.status ||
                    o_succeeded !== want.fit || o_last_of_run !== want.last)
                    report_mismatch($sformatf(
                        "got char=%02h status=%0b ok=%0b last=%0b, want %02h %0b %0b %0b",
                        o_out_char, o_is_status, o_succeeded, o_last_of_run,
                        want.ch, want.status, want.fit, want.last));
            end
        end
    end

    // The receiver stalls at random while gaps are enabled.
    always @(posedge i_clk)
        i_out_stall <= traffic_gaps && ($urandom_range(99) < 29);

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("time_format_code_translator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------ main flow

    initial begin
        int phase;
        t_row row;
        buf_len      = BUF_LEN_RESET;
        hold_results = 1'b0;
        live_items   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        restart_pattern();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table first, starting under the reset buffer length.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_LENGTH: apply_length(row.data);
                ROW_CHECK: begin
                    // The model still advances; its output is replaced by
                    // the typed-in result.
                    hold_results = 1'b1;
                    send_byte(row.data[7:0]);
                    hold_results = 1'b0;
                    pending_chars.push_back(t_out_char'{row.e_char, row.e_status,
                                                        row.e_fit, 1'b1});
                end
                default: send_byte(row.data[7:0]);
            endcase
        end
        send_byte(CH_NUL);

        // Random phases, each under its own buffer length. One phase runs
        // without any idling on either side.
        for (phase = 0; phase <= 6; phase++) begin
            apply_length(phase < 6 ? PHASE_LENGTHS[phase] : 16'($urandom_range(2, 40)));
            traffic_gaps = (phase != CALM_PHASE);
            live_items = 0;
            while (live_items < PHASE_ITEMS) begin
                if ($urandom_range(99) < 10)
                    send_noise();
                else
                    send_pattern();
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(19) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("time_format_code_translator test passed");
        else
            $display("time_format_code_translator test failed");
        $finish;
    end

endmodule
